>>> rtl/core/dual_servo_sweep_sequencer_unit_defines.svh
// Assertion macros shared by the servo sweep sequencer RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef DUAL_SERVO_SWEEP_SEQUENCER_UNIT_DEFINES_SVH
`define DUAL_SERVO_SWEEP_SEQUENCER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define DSSS_CHECK(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("dsss check failed");

// A condition that, once seen, forces another one at the next clock edge.
`define DSSS_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dsss sequence check failed");

`endif

>>> rtl/core/dsss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the dual servo sweep sequencer.
// No dependencies; the RTL files and the testbench import this package.
package dsss_pkg;

	// Field and register widths.
	localparam int PERIOD_W   = 16;
	localparam int DIVIDER_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int DUTY_W     = 15;
	localparam int CMP_W      = 13;
	localparam int PHASE_W    = 3;

	// Shared divider widths.
	localparam int DIVIDEND_W = 34;
	localparam int DIVISOR_W  = 14;
	localparam int QUO_W      = 15;
	localparam int QBITS_W    = 4;
	localparam int MULT_X_W   = 18;

	// Reciprocal path widths for the division by 10000.
	localparam int SCALED_W     = 23;
	localparam int RECIP_W      = 24;
	localparam int RECIP_PROD_W = 47;
	localparam int RECIP_SHIFT  = 33;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 1'b1;

	// Reset values and sweep constants.
	localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 16'd478;
	localparam logic [DIVIDER_W-1:0] DIVIDER_RESET = 8'd1;
	localparam logic [DUTY_W-1:0]    DUTY_RESET    = 15'd50;
	localparam logic [QUO_W-1:0]     STEP_BOTTOM   = 15'd0;
	localparam logic [QUO_W-1:0]     STEP_MID      = 15'd50;
	localparam logic [QUO_W-1:0]     STEP_TOP      = 15'd100;

	// Compare value = floor(period * (CMP_BASE + CMP_SCALE * d) / 10000), capped
	// at CMP_MAX. A product at or above CMP_LIMIT (8192 * 10000) saturates.
	// Below it, floor(x / 10000) = ((x >> 4) * RECIP_MUL) >> RECIP_SHIFT exactly.
	localparam logic [MULT_X_W-1:0]   CMP_BASE   = 18'd500;
	localparam logic [MULT_X_W-1:0]   CMP_SCALE  = 18'd5;
	localparam logic [DIVIDEND_W-1:0] CMP_LIMIT  = 34'd81920000;
	localparam logic [CMP_W-1:0]      CMP_MAX    = 13'd8191;
	localparam logic [RECIP_W-1:0]    RECIP_MUL  = 24'd13743896;
	localparam logic [QBITS_W-1:0]    DUTY_QBITS = 4'(DUTY_W);

	// Direction codes, two's complement -1, 0, +1.
	typedef logic [1:0] dir_t;
	localparam dir_t DIR_ZERO = 2'b00;
	localparam dir_t DIR_POS  = 2'b01;
	localparam dir_t DIR_NEG  = 2'b11;

	// Phase codes reported per channel.
	typedef logic [PHASE_W-1:0] phase_t;
	localparam phase_t PH_NONE     = 3'd0;
	localparam phase_t PH_TOP      = 3'd1;
	localparam phase_t PH_MID_FALL = 3'd2;
	localparam phase_t PH_BOTTOM   = 3'd3;
	localparam phase_t PH_MID_RISE = 3'd4;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_IDLE,
		S_E1Q, S_E1QW, S_E1M, S_E1R, S_E1S,
		S_E2Q, S_E2QW, S_E2M, S_E2R, S_E2S,
		S_A1, S_A1W, S_A1U,
		S_A2, S_A2W, S_A2U,
		S_DONE
	} seq_state_t;

	// Request to and response from the shared divider.
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
		logic [QBITS_W-1:0]    qbits;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/core/dual_servo_sweep_sequencer_unit.sv
`timescale 1ns / 1ps
// Top level of the dual servo sweep sequencer: sequencer, channel state and
// result register. Depends on dsss_pkg, dsss_div and the assertion macro header.
//
//   Channel   Handshake              Payload
//   -------   --------------------   ---------------------------------------------
//   input     in_valid / in_ready    disable_all
//   output    out_valid / out_ready  ch1_compare ch1_write ch2_compare ch2_write
//                                    ch1_phase ch2_phase
//   config    cfg_write_en           cfg_index cfg_data (no wait, no read-back)
//
// Most of an item's work falls on the shared radix-2 divider, which computes
// two to four duty quotients per item depending on how many channels are
// moving; each compare then passes through the product, the reciprocal
// multiply by 1/10000 and the saturation, in that order.
// in_ready is high only while the sequencer is idle. A finished result waits in
// the output register, so the next item is accepted while it is still pending;
// a second finished result waits in the sequencer until the register is free.
// Reset is asynchronous and active low; there is no clearing pass.
module dual_servo_sweep_sequencer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              disable_all,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dsss_pkg::CMP_W-1:0]        ch1_compare,
	output logic                              ch1_write,
	output logic [dsss_pkg::CMP_W-1:0]        ch2_compare,
	output logic                              ch2_write,
	output logic [dsss_pkg::PHASE_W-1:0]      ch1_phase,
	output logic [dsss_pkg::PHASE_W-1:0]      ch2_phase,
	input  logic                              cfg_write_en,
	input  logic [dsss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dsss_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dsss_pkg::*;

	`include "dual_servo_sweep_sequencer_unit_defines.svh"

	// Direction after reaching a sweep end; the middle leaves it alone.
	function automatic dir_t dir_after(input logic [QUO_W-1:0] q, input dir_t dir);
		dir_t r;
		r = dir;
		if (q == STEP_BOTTOM) begin
			r = DIR_POS;
		end else if (q == STEP_TOP) begin
			r = DIR_NEG;
		end
		return r;
	endfunction

	// Phase reached after a step, judged with the direction of travel.
	function automatic phase_t phase_of(input logic [QUO_W-1:0] q, input dir_t dir);
		phase_t p;
		p = PH_NONE;
		if (q == STEP_BOTTOM) begin
			p = PH_BOTTOM;
		end else if (q == STEP_MID) begin
			p = (dir == DIR_POS) ? PH_MID_RISE : PH_MID_FALL;
		end else if (q == STEP_TOP) begin
			p = PH_TOP;
		end
		return p;
	endfunction

	seq_state_t state_q, state_d;

	// Configuration registers.
	logic [PERIOD_W-1:0]  period_q;
	logic [DIVIDER_W-1:0] divider_q;
	logic [DIVIDER_W-1:0] eff_div;

	// Channel state.
	logic [DUTY_W-1:0] ch1_duty_q, ch2_duty_q;
	dir_t              ch1_dir_q, ch2_dir_q;
	dir_t              ch1_sdir_q, ch2_sdir_q;
	logic              ch1_en_q, ch2_en_q;
	logic              ch1_started_q, ch2_started_q;
	logic              ch2_parity_q;

	// Item in flight and its staged result.
	logic                    dis_q;
	logic [DIVIDEND_W-1:0]   prod_q;
	logic [RECIP_PROD_W-1:0] recip_q;
	logic                    ovf_q;
	logic [CMP_W-1:0]        res_cmp1_q, res_cmp2_q;
	logic                    res_wr1_q, res_wr2_q;
	phase_t                  res_ph1_q, res_ph2_q;

	// Output register.
	logic             out_valid_q;
	logic [CMP_W-1:0] out_cmp1_q, out_cmp2_q;
	logic             out_wr1_q, out_wr2_q;
	phase_t           out_ph1_q, out_ph2_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Combinational helpers.
	logic              act1, act2;
	logic [DUTY_W-1:0] duty1_step, duty2_step;
	logic              wr1, wr2;
	logic [DUTY_W-1:0] emit_x;
	logic [MULT_X_W-1:0] mult_x;
	logic [CMP_W-1:0]  cmp_val;
	dir_t              dir1_adv, dir2_adv;
	phase_t            ph1, ph2;
	logic              hand1, hand2;
	logic              load_out;
	logic              div_wait;

	assign eff_div = (divider_q == '0) ? DIVIDER_W'(1) : divider_q;

	// A channel moves only when enabled with a nonzero direction.
	assign act1 = ch1_en_q && (ch1_dir_q != DIR_ZERO);
	assign act2 = ch2_en_q && (ch2_dir_q != DIR_ZERO);
	assign duty1_step = (ch1_dir_q == DIR_POS) ? ch1_duty_q + DUTY_W'(1)
		: ch1_duty_q - DUTY_W'(1);
	assign duty2_step = (ch2_dir_q == DIR_POS) ? ch2_duty_q + DUTY_W'(1)
		: ch2_duty_q - DUTY_W'(1);

	// A disabled channel still loads its compare, at the middle of the sweep.
	// A halted channel loads nothing and reports a zero compare.
	assign wr1 = !ch1_en_q || (ch1_dir_q != DIR_ZERO);
	assign wr2 = !ch2_en_q || (ch2_dir_q != DIR_ZERO);

	always_comb begin
		if (state_q == S_E1M) begin
			emit_x = ch1_en_q ? div_rsp.quotient : STEP_MID;
		end else begin
			emit_x = ch2_en_q ? div_rsp.quotient : STEP_MID;
		end
		mult_x = CMP_BASE + MULT_X_W'(emit_x) * CMP_SCALE;
	end

	// The reciprocal product is exact only below the saturation limit, where
	// the quotient fits in the compare width.
	assign cmp_val = ovf_q ? CMP_MAX : recip_q[RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];

	// Handoff rules. Channel 1 hands over on any phase until it has passed its
	// first rising middle, and on every rising middle after that. Channel 2
	// does the same until started, then only on odd full periods.
	assign dir1_adv = dir_after(div_rsp.quotient, ch1_dir_q);
	assign ph1      = phase_of(div_rsp.quotient, ch1_dir_q);
	assign hand1    = (ph1 == PH_MID_RISE) || (!ch1_started_q && (ph1 != PH_NONE));

	assign dir2_adv = dir_after(div_rsp.quotient, ch2_dir_q);
	assign ph2      = phase_of(div_rsp.quotient, ch2_dir_q);
	assign hand2    = !ch2_started_q ? (ph2 != PH_NONE)
		: ((ph2 == PH_MID_RISE) && !ch2_parity_q);

	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign div_wait = (state_q == S_E1QW) || (state_q == S_E2QW) ||
		(state_q == S_A1W) || (state_q == S_A2W);

	// Sequencer: next state and divider requests.
	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = DIVISOR_W'(eff_div);
		div_req.qbits    = DUTY_QBITS;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_E1Q;
				end
			end
			S_E1Q: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIVIDEND_W'(ch1_duty_q);
				div_req.divisor  = DIVISOR_W'(eff_div);
				div_req.qbits    = DUTY_QBITS;
				state_d          = S_E1QW;
			end
			S_E1QW: begin
				if (div_rsp.done) begin
					state_d = S_E1M;
				end
			end
			S_E1M: begin
				state_d = S_E1R;
			end
			S_E1R: begin
				state_d = S_E1S;
			end
			S_E1S: begin
				state_d = S_E2Q;
			end
			S_E2Q: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIVIDEND_W'(ch2_duty_q);
				div_req.divisor  = DIVISOR_W'(eff_div);
				div_req.qbits    = DUTY_QBITS;
				state_d          = S_E2QW;
			end
			S_E2QW: begin
				if (div_rsp.done) begin
					state_d = S_E2M;
				end
			end
			S_E2M: begin
				state_d = S_E2R;
			end
			S_E2R: begin
				state_d = S_E2S;
			end
			S_E2S: begin
				state_d = S_A1;
			end
			S_A1: begin
				div_req.start    = act1;
				div_req.dividend = DIVIDEND_W'(duty1_step);
				div_req.divisor  = DIVISOR_W'(eff_div);
				div_req.qbits    = DUTY_QBITS;
				state_d          = act1 ? S_A1W : S_A2;
			end
			S_A1W: begin
				if (div_rsp.done) begin
					state_d = S_A1U;
				end
			end
			S_A1U: begin
				state_d = S_A2;
			end
			S_A2: begin
				div_req.start    = act2;
				div_req.dividend = DIVIDEND_W'(duty2_step);
				div_req.divisor  = DIVISOR_W'(eff_div);
				div_req.qbits    = DUTY_QBITS;
				state_d          = act2 ? S_A2W : S_DONE;
			end
			S_A2W: begin
				if (div_rsp.done) begin
					state_d = S_A2U;
				end
			end
			S_A2U: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; the user must issue them only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PERIOD_RESET;
			divider_q <= DIVIDER_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_PERIOD:  period_q  <= cfg_data[PERIOD_W-1:0];
				REG_DIVIDER: divider_q <= cfg_data[DIVIDER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Channel state: advance, handoff and the end-of-tick disable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch1_duty_q    <= DUTY_RESET;
			ch1_dir_q     <= DIR_POS;
			ch1_sdir_q    <= DIR_POS;
			ch1_en_q      <= 1'b1;
			ch1_started_q <= 1'b0;
			ch2_duty_q    <= DUTY_RESET;
			ch2_dir_q     <= DIR_ZERO;
			ch2_sdir_q    <= DIR_POS;
			ch2_en_q      <= 1'b1;
			ch2_started_q <= 1'b0;
			ch2_parity_q  <= 1'b0;
		end else begin
			if ((state_q == S_A1) && act1) begin
				ch1_duty_q <= duty1_step;
			end
			if ((state_q == S_A2) && act2) begin
				ch2_duty_q <= duty2_step;
			end
			if (state_q == S_A1U) begin
				if (ph1 == PH_MID_RISE) begin
					ch1_started_q <= 1'b1;
				end
				if (hand1) begin
					ch1_sdir_q <= dir1_adv;
					ch1_dir_q  <= DIR_ZERO;
					ch2_dir_q  <= ch2_sdir_q;
				end else begin
					ch1_dir_q <= dir1_adv;
				end
			end
			if (state_q == S_A2U) begin
				if (ph2 == PH_MID_RISE) begin
					ch2_started_q <= 1'b1;
					ch2_parity_q  <= !ch2_started_q || !ch2_parity_q;
				end
				if (hand2) begin
					ch2_sdir_q <= dir2_adv;
					ch2_dir_q  <= DIR_ZERO;
					ch1_dir_q  <= ch1_sdir_q;
				end else begin
					ch2_dir_q <= dir2_adv;
				end
			end
			if (load_out && dis_q) begin
				ch1_en_q <= 1'b0;
				ch2_en_q <= 1'b0;
			end
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			dis_q <= disable_all;
		end
		if ((state_q == S_E1M) || (state_q == S_E2M)) begin
			prod_q <= DIVIDEND_W'(period_q) * DIVIDEND_W'(mult_x);
		end
		if ((state_q == S_E1R) || (state_q == S_E2R)) begin
			recip_q <= RECIP_PROD_W'(prod_q[SCALED_W+3:4]) * RECIP_PROD_W'(RECIP_MUL);
			ovf_q   <= prod_q >= CMP_LIMIT;
		end
		if (state_q == S_E1S) begin
			res_wr1_q  <= wr1;
			res_cmp1_q <= wr1 ? cmp_val : '0;
		end
		if (state_q == S_E2S) begin
			res_wr2_q  <= wr2;
			res_cmp2_q <= wr2 ? cmp_val : '0;
		end
		if (state_q == S_A1) begin
			res_ph1_q <= PH_NONE;
		end else if (state_q == S_A1U) begin
			res_ph1_q <= ph1;
		end
		if (state_q == S_A2) begin
			res_ph2_q <= PH_NONE;
		end else if (state_q == S_A2U) begin
			res_ph2_q <= ph2;
		end
	end

	// Output register: holds a result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_cmp1_q <= res_cmp1_q;
			out_wr1_q  <= res_wr1_q;
			out_cmp2_q <= res_cmp2_q;
			out_wr2_q  <= res_wr2_q;
			out_ph1_q  <= res_ph1_q;
			out_ph2_q  <= res_ph2_q;
		end
	end

	dsss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign ch1_compare = out_cmp1_q;
	assign ch1_write   = out_wr1_q;
	assign ch2_compare = out_cmp2_q;
	assign ch2_write   = out_wr2_q;
	assign ch1_phase   = out_ph1_q;
	assign ch2_phase   = out_ph2_q;

	`DSSS_CHECK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`DSSS_CHECK(a_done_in_wait, !div_rsp.done || div_wait)
	`DSSS_CHECK_NEXT(a_load_sets_valid, load_out, out_valid && in_ready)

endmodule

>>> rtl/core/dsss_div.sv
`timescale 1ns / 1ps
// Shared restoring divider with a saturating quotient of qbits bits.
// Depends on dsss_pkg and the block's assertion macro header.
module dsss_div (
	input  logic              clk,
	input  logic              arst_n,
	input  dsss_pkg::div_req_t req,
	output dsss_pkg::div_rsp_t rsp
);
	import dsss_pkg::*;

	`include "dual_servo_sweep_sequencer_unit_defines.svh"

	logic                  busy_q;
	logic                  chk_q;
	logic                  done_q;
	logic [DIVIDEND_W-1:0] rem_q;
	logic [DIVIDEND_W-1:0] ds_q;
	logic [QUO_W-1:0]      quo_q;
	logic [QBITS_W-1:0]    cnt_q;
	logic [QBITS_W-1:0]    qbits_q;
	logic                  ge;
	logic [QUO_W:0]        ones;

	assign ge   = rem_q >= ds_q;
	assign ones = ((QUO_W+1)'(1) << qbits_q) - (QUO_W+1)'(1);

	// The first busy cycle checks for overflow against divisor << qbits;
	// each later cycle resolves one quotient bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chk_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				chk_q  <= 1'b1;
			end else if (busy_q) begin
				if (chk_q) begin
					chk_q <= 1'b0;
					if (ge) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else if (cnt_q == QBITS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= req.dividend;
			ds_q    <= DIVIDEND_W'(req.divisor) << req.qbits;
			cnt_q   <= req.qbits;
			qbits_q <= req.qbits;
			quo_q   <= '0;
		end else if (busy_q) begin
			if (chk_q) begin
				if (ge) begin
					quo_q <= ones[QUO_W-1:0];
				end else begin
					ds_q <= ds_q >> 1;
				end
			end else begin
				if (ge) begin
					rem_q <= rem_q - ds_q;
				end
				quo_q <= {quo_q[QUO_W-2:0], ge};
				ds_q  <= ds_q >> 1;
				cnt_q <= cnt_q - QBITS_W'(1);
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`DSSS_CHECK(a_no_start_when_busy, !(req.start && busy_q))
	`DSSS_CHECK(a_done_not_busy, !(done_q && busy_q))
	`DSSS_CHECK_NEXT(a_start_busy, req.start, busy_q && chk_q)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_servo_sweep_sequencer_unit: ticks go in on
// a valid/ready channel and each result is checked against a cycle-free model.
// Depends on dsss_pkg and the RTL of the block; reads no files.
module testbench;
	import dsss_pkg::*;

	// Widths and constants of the sweep as the model sees them.
	localparam int SWEEP_DUTY_BITS = 15;
	localparam logic [SWEEP_DUTY_BITS-1:0] BOTTOM_STEP = 15'd0;
	localparam logic [SWEEP_DUTY_BITS-1:0] MID_STEP    = 15'd50;
	localparam logic [SWEEP_DUTY_BITS-1:0] TOP_STEP    = 15'd100;
	localparam logic [63:0] CMP_OFFSET   = 64'd500;
	localparam logic [63:0] CMP_PER_STEP = 64'd5;
	localparam logic [63:0] CMP_DENOM    = 64'd10000;
	localparam logic [63:0] CMP_CEILING  = 64'd8191;
	localparam int MAX_REPORTS = 40;

	// One channel of the model.
	typedef struct packed {
		logic [SWEEP_DUTY_BITS-1:0] duty;
		dir_t                       dir;
		dir_t                       saved_dir;
		logic                       enabled;
		logic                       started;
	} servo_state_t;

	// The fields of one result item.
	typedef struct packed {
		logic [CMP_W-1:0] ch1_cmp;
		logic             ch1_wr;
		logic [CMP_W-1:0] ch2_cmp;
		logic             ch2_wr;
		phase_t           ch1_ph;
		phase_t           ch2_ph;
	} tick_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  disable_all;
	logic                  out_valid;
	logic                  out_ready;
	logic [CMP_W-1:0]      ch1_compare;
	logic                  ch1_write;
	logic [CMP_W-1:0]      ch2_compare;
	logic                  ch2_write;
	phase_t                ch1_phase;
	phase_t                ch2_phase;
	logic                  cfg_write_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Model state: both channels, the parity of channel 2's full periods and
	// the two configuration registers.
	servo_state_t servo [2];
	logic         ch2_odd_period;
	logic [15:0]  period_reg;
	logic [7:0]   divider_reg;

	// Results still owed by the block, oldest first.
	tick_result_t expected_q [$];

	int fail_count;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_request;

	dual_servo_sweep_sequencer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.disable_all  (disable_all),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ch1_compare  (ch1_compare),
		.ch1_write    (ch1_write),
		.ch2_compare  (ch2_compare),
		.ch2_write    (ch2_write),
		.ch1_phase    (ch1_phase),
		.ch2_phase    (ch2_phase),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A divider register of zero behaves as one.
	function automatic logic [7:0] effective_divider();
		return (divider_reg == 8'd0) ? 8'd1 : divider_reg;
	endfunction

	// Compare value for a step count, exact integer math with flooring, and
	// clipped to the largest value the 13-bit output can carry.
	function automatic logic [CMP_W-1:0] compare_for(logic [SWEEP_DUTY_BITS-1:0] steps);
		logic [63:0] v;
		v = 64'(period_reg) * (CMP_OFFSET + CMP_PER_STEP * 64'(steps)) / CMP_DENOM;
		return (v > CMP_CEILING) ? CMP_CEILING[CMP_W-1:0] : v[CMP_W-1:0];
	endfunction

	// Output of one channel as {write, compare}. A disabled channel parks at
	// the midpoint; an enabled but halted one writes nothing.
	function automatic logic [CMP_W:0] servo_output(int k);
		if (!servo[k].enabled)
			return {1'b1, compare_for(MID_STEP)};
		if (servo[k].dir != DIR_ZERO)
			return {1'b1, compare_for(servo[k].duty / effective_divider())};
		return '0;
	endfunction

	// Moves one channel a single duty step and reports the point it reached.
	// The duty counter wraps at its 15-bit width.
	function automatic phase_t advance_servo(int k);
		logic [SWEEP_DUTY_BITS-1:0] q;
		if (!servo[k].enabled || servo[k].dir == DIR_ZERO)
			return PH_NONE;
		if (servo[k].dir == DIR_POS)
			servo[k].duty = servo[k].duty + 1'b1;
		else
			servo[k].duty = servo[k].duty - 1'b1;
		q = servo[k].duty / effective_divider();
		if (q == BOTTOM_STEP) begin
			servo[k].dir = DIR_POS;
			return PH_BOTTOM;
		end
		if (q == MID_STEP)
			return (servo[k].dir == DIR_POS) ? PH_MID_RISE : PH_MID_FALL;
		if (q == TOP_STEP) begin
			servo[k].dir = DIR_NEG;
			return PH_TOP;
		end
		return PH_NONE;
	endfunction

	// The giver stops and remembers its direction; the taker picks up the
	// direction it remembered when it last stopped.
	function automatic void hand_over(int giver, int taker);
		servo[giver].saved_dir = servo[giver].dir;
		servo[giver].dir = DIR_ZERO;
		servo[taker].dir = servo[taker].saved_dir;
	endfunction

	function automatic logic is_turn_point(phase_t ph);
		return ph == PH_TOP || ph == PH_MID_FALL || ph == PH_BOTTOM;
	endfunction

	// One tick of the sweep: outputs from the state at the start of the tick,
	// then channel 1, then channel 2, then the disable request.
	function automatic tick_result_t predict_tick(logic disable_now);
		tick_result_t r;
		{r.ch1_wr, r.ch1_cmp} = servo_output(0);
		{r.ch2_wr, r.ch2_cmp} = servo_output(1);

		r.ch1_ph = advance_servo(0);
		if (r.ch1_ph == PH_MID_RISE) begin
			servo[0].started = 1'b1;
			hand_over(0, 1);
		end else if (!servo[0].started && is_turn_point(r.ch1_ph)) begin
			hand_over(0, 1);
		end

		r.ch2_ph = advance_servo(1);
		if (!servo[1].started) begin
			if (is_turn_point(r.ch2_ph)) begin
				hand_over(1, 0);
			end else if (r.ch2_ph == PH_MID_RISE) begin
				servo[1].started = 1'b1;
				ch2_odd_period = 1'b1;
				hand_over(1, 0);
			end
		end else if (r.ch2_ph == PH_MID_RISE) begin
			// Once running, channel 2 hands back only on odd full periods.
			ch2_odd_period = ~ch2_odd_period;
			if (ch2_odd_period)
				hand_over(1, 0);
		end

		if (disable_now) begin
			servo[0].enabled = 1'b0;
			servo[1].enabled = 1'b0;
		end
		return r;
	endfunction

	// Picks a divider that keeps every channel's step count at or below the
	// top point, so that no sweep climbs past it and runs away.
	function automatic logic [7:0] pick_divider();
		int floor_div;
		int top;
		int k;
		floor_div = 1;
		for (k = 0; k < 2; k++) begin
			if (int'(servo[k].duty) / 101 + 1 > floor_div)
				floor_div = int'(servo[k].duty) / 101 + 1;
		end
		top = (floor_div + 3 > 255) ? 255 : floor_div + 3;
		case ($urandom_range(7))
			0: return 8'($urandom_range(255, floor_div));
			1: return (floor_div == 1) ? 8'd0 : 8'(floor_div);
			default: return 8'($urandom_range(top, floor_div));
		endcase
	endfunction

	// Writes the period register and then the divider register. The divider write
	// carries random upper data bits, which the block must drop.
	task automatic write_settings(input logic [15:0] period, input logic [7:0] divider);
		cfg_write_en <= 1'b1;
		cfg_index <= REG_PERIOD;
		cfg_data <= period;
		@(posedge clk);
		period_reg = period;
		@(negedge clk);
		cfg_index <= REG_DIVIDER;
		cfg_data <= {8'($urandom), divider};
		@(posedge clk);
		divider_reg = divider;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Offers one tick item and returns at the falling edge after it was taken.
	// Valid is left high so the next item can follow without a gap.
	task automatic send_tick(input logic disable_now);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		disable_all <= disable_now;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_q.push_back(predict_tick(disable_now));
		@(negedge clk);
	endtask

	// Stops sending and waits until every result owed has arrived. Each item
	// yields a result, so the block is idle once the queue is empty.
	task automatic idle_block();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Receiver: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		int held;
		held = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request != 0) begin
				held = stall_request;
				stall_request = 0;
			end
			if (held != 0) begin
				held--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Every accepted result is matched against the oldest expectation.
	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: result item with nothing expected, got %0d %0d %0d %0d %0d %0d",
						$time, ch1_compare, ch1_write, ch2_compare, ch2_write,
						ch1_phase, ch2_phase);
			end else begin
				want = expected_q.pop_front();
				check_field("ch1_compare", want.ch1_cmp, ch1_compare);
				check_field("ch1_write", want.ch1_wr, ch1_write);
				check_field("ch2_compare", want.ch2_cmp, ch2_compare);
				check_field("ch2_write", want.ch2_wr, ch2_write);
				check_field("ch1_phase", want.ch1_ph, ch1_phase);
				check_field("ch2_phase", want.ch2_ph, ch2_phase);
			end
		end
	end

	// The first ticks after reset: channel 1 sweeps, channel 2 is halted and
	// so writes nothing.
	task automatic test_reset_defaults();
		repeat (4) send_tick(1'b0);
		idle_block();
	endtask

	// Register extremes: the largest and smallest periods, a zero period, a
	// zero divider, and the largest divider. With the largest divider the
	// step count is zero at once, so the channels trade bottom points.
	task automatic test_config_extremes();
		write_settings(16'hFFFF, 8'd0);
		repeat (3) send_tick(1'b0);
		idle_block();
		write_settings(16'd1, 8'd1);
		repeat (2) send_tick(1'b0);
		idle_block();
		write_settings(16'd0, 8'd255);
		repeat (6) send_tick(1'b0);
		idle_block();
		write_settings(16'd478, 8'd1);
		repeat (2) send_tick(1'b0);
		idle_block();
	endtask

	// Saturation of the compare value. With a divider of three a channel
	// climbs to a duty of about 300; once it is on its way down well above
	// the midpoint, the divider drops to one so that the step count is far
	// above the top and the compare for the full period overflows 13 bits.
	task automatic test_compare_saturation();
		int guard;
		int k;
		logic found;
		write_settings(16'hFFFF, 8'd3);
		found = 1'b0;
		for (guard = 0; guard < 1200 && !found; guard++) begin
			send_tick(1'b0);
			idle_block();
			for (k = 0; k < 2; k++) begin
				if (servo[k].enabled && servo[k].dir == DIR_NEG && servo[k].duty > 15'd160)
					found = 1'b1;
			end
		end
		if (found) begin
			write_settings(16'hFFFF, 8'd1);
			repeat (30) send_tick(1'b0);
			idle_block();
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering items, so the block fills up and has to stall its input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_request = 700;
		repeat (10) send_tick(1'b0);
		idle_block();
	endtask

	// The bulk of the run: sweeps under changing settings and three idling
	// profiles. Settings change only between bursts, with the block idle.
	task automatic test_random_sweeps();
		int profile;
		int left;
		int burst;
		logic [15:0] period;
		for (profile = 0; profile < 3; profile++) begin
			case (profile)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct = 76;
				end
				1: begin
					send_idle_pct = 76;
					recv_idle_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			left = 540;
			while (left > 0) begin
				burst = $urandom_range(200, 40);
				if (burst > left)
					burst = left;
				case ($urandom_range(9))
					0: period = 16'hFFFF;
					1: period = 16'd1;
					2: period = 16'd0;
					default: period = 16'($urandom_range(65535, 1));
				endcase
				write_settings(period, pick_divider());
				repeat (burst) send_tick(1'b0);
				idle_block();
				left -= burst;
			end
		end
	endtask

	// Disabling is permanent until reset, so it is exercised last. Afterwards
	// both channels write the midpoint compare under any settings.
	task automatic test_disable_all();
		send_idle_pct = 16;
		recv_idle_pct = 76;
		send_tick(1'b0);
		send_tick(1'b1);
		repeat (4) send_tick(1'($urandom_range(1)));
		idle_block();
		write_settings(16'hFFFF, 8'd200);
		repeat (4) send_tick(1'($urandom_range(1)));
		idle_block();
		write_settings(16'd0, 8'd0);
		repeat (3) send_tick(1'b0);
		idle_block();
	endtask

	// Main sequence. Inputs get known values at time zero, the model and the
	// block come out of reset together, and the tests run in turn.
	initial begin
		int k;
		in_valid = 1'b0;
		disable_all = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = REG_PERIOD;
		cfg_data = '0;
		fail_count = 0;
		stall_request = 0;
		send_idle_pct = 16;
		recv_idle_pct = 76;

		period_reg = 16'd478;
		divider_reg = 8'd1;
		for (k = 0; k < 2; k++) begin
			servo[k].duty = MID_STEP;
			servo[k].saved_dir = DIR_POS;
			servo[k].enabled = 1'b1;
			servo[k].started = 1'b0;
		end
		servo[0].dir = DIR_POS;
		servo[1].dir = DIR_ZERO;
		ch2_odd_period = 1'b0;

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_config_extremes();
		test_compare_saturation();
		test_backpressure();
		test_random_sweeps();
		test_disable_all();

		// Room for any stray result to show up after the last expected one.
		repeat (120) @(negedge clk);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#50000000;
		$display("Verification failed");
		$finish;
	end

endmodule

>>> dual_servo_sweep_sequencer_unit.f
+incdir+rtl/core
rtl/core/dsss_pkg.sv
rtl/core/dsss_div.sv
rtl/core/dual_servo_sweep_sequencer_unit.sv
bench/testbench.sv
